>>> design/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg: shared types and codes for the bounded deque
// Action and status codes, plus the command and status bundles passed
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_OUT_W = 5;

  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;
  localparam logic [2:0] ACT_DELETE     = 3'd4;
  localparam logic [2:0] ACT_SEARCH     = 3'd5;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic       push_front;
    logic       push_back;
    logic       pop_front;   // head moves inward, count drops
    logic       pop_back;    // count drops
    logic       scan_init;   // latch key, read index to front
    logic       shift_init;  // read index to one past the hit
    logic       rd_issue;    // issue a read at the read index
    logic       shift_run;   // write returning data one slot frontwards
    logic       emit;
    logic [1:0] status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic hit;       // returning data equals the key
    logic rd_valid;
    logic at_first;  // returning data is the front entry
    logic at_last;   // returning data is the back entry
  } stat_t;

endpackage

>>> design/bdq_datapath.sv
// ----------------------------------------------------------------------------
// bdq_datapath: entry store, pointers and result register
// Circular buffer with a head pointer and count, one registered read port
// for scans and compaction, and the registered result outputs.
// ----------------------------------------------------------------------------
module bdq_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic signed [bdq_pkg::VALUE_W-1:0]     value,
  input  bdq_pkg::cmd_t                          cmd,
  output bdq_pkg::stat_t                         stat,
  output logic                                   done,
  output logic [1:0]                             status,
  output logic [bdq_pkg::COUNT_OUT_W-1:0]        entry_count
);
  import bdq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = $clog2(CAPACITY);

  logic [VALUE_W-1:0] mem [CAPACITY];

  logic [PW-1:0] head, head_next, head_dec, head_inc;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] ri, ri_next, rd_idx;
  logic          rd_valid, issue;
  logic [VALUE_W-1:0] key, rd_data;
  logic          we;
  logic [PW-1:0] wr_addr, rd_addr;
  logic [VALUE_W-1:0] wr_data;

  // logical position -> physical slot, wrapping at CAPACITY
  function automatic logic [PW-1:0] phys(input logic [PW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(CAPACITY)) sum = sum - (CW+1)'(CAPACITY);
    return sum[PW-1:0];
  endfunction

  assign head_dec = (head == '0) ? PW'(CAPACITY - 1) : head - PW'(1);
  assign head_inc = (head == PW'(CAPACITY - 1)) ? '0 : head + PW'(1);
  assign issue    = cmd.rd_issue && (ri < count);
  assign rd_addr  = phys(head, ri);

  always_comb begin
    head_next  = head;
    count_next = count;
    we         = 1'b0;
    wr_addr    = phys(head, rd_idx - CW'(1));
    wr_data    = rd_data;
    priority if (cmd.push_front) begin
      head_next  = head_dec;
      count_next = count + CW'(1);
      we         = 1'b1;
      wr_addr    = head_dec;
      wr_data    = value;
    end else if (cmd.push_back) begin
      count_next = count + CW'(1);
      we         = 1'b1;
      wr_addr    = phys(head, count);
      wr_data    = value;
    end else if (cmd.pop_front) begin
      head_next  = head_inc;
      count_next = count - CW'(1);
    end else if (cmd.pop_back) begin
      count_next = count - CW'(1);
      we         = cmd.shift_run && rd_valid;  // last compaction move
    end else begin
      we         = cmd.shift_run && rd_valid;
    end
  end

  always_comb begin
    priority if (cmd.scan_init) begin
      ri_next = '0;
    end else if (cmd.shift_init) begin
      ri_next = rd_idx + CW'(1);
    end else if (issue) begin
      ri_next = ri + CW'(1);
    end else begin
      ri_next = ri;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      rd_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      head     <= head_next;
      count    <= count_next;
      rd_valid <= issue;
      done     <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    ri <= ri_next;
    if (issue) begin
      rd_idx <= ri;
    end
    if (cmd.scan_init) begin
      key <= value;
    end
    status      <= cmd.status;
    entry_count <= COUNT_OUT_W'(count_next);
  end

  assign stat.empty    = (count == '0);
  assign stat.full     = (count == CW'(CAPACITY));
  assign stat.hit      = rd_valid && (rd_data == key);
  assign stat.rd_valid = rd_valid;
  assign stat.at_first = (rd_idx == '0);
  assign stat.at_last  = (rd_idx == count - CW'(1));

endmodule

>>> design/bdq_controller.sv
// ----------------------------------------------------------------------------
// bdq_controller: request sequencer
// Decodes each request, runs the front-to-back scan for search and delete,
// and the compaction pass that closes the gap after an interior delete.
// ----------------------------------------------------------------------------
module bdq_controller (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [2:0]     action,
  input  bdq_pkg::stat_t stat,
  output bdq_pkg::cmd_t  cmd,
  output logic           busy
);
  import bdq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_SHIFT = 3'b100
  } state_t;

  state_t state, state_next;
  logic   is_del, is_del_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.status  = ST_DONE;
    state_next  = state;
    is_del_next = is_del;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.emit = 1'b1;
          unique case (action)
            ACT_PUSH_FRONT: begin
              if (stat.full) cmd.status = ST_FULL;
              else cmd.push_front = 1'b1;
            end
            ACT_PUSH_BACK: begin
              if (stat.full) cmd.status = ST_FULL;
              else cmd.push_back = 1'b1;
            end
            ACT_POP_FRONT: begin
              if (stat.empty) cmd.status = ST_EMPTY;
              else cmd.pop_front = 1'b1;
            end
            ACT_POP_BACK: begin
              if (stat.empty) cmd.status = ST_EMPTY;
              else cmd.pop_back = 1'b1;
            end
            ACT_DELETE, ACT_SEARCH: begin
              if (stat.empty) begin
                cmd.status = ST_MISSING;
              end else begin
                cmd.emit      = 1'b0;
                cmd.scan_init = 1'b1;
                is_del_next   = (action == ACT_DELETE);
                state_next    = S_SCAN;
              end
            end
            default: ;  // unused codes: no change
          endcase
        end
      end
      S_SCAN: begin
        if (stat.hit) begin
          if (!is_del) begin
            cmd.emit   = 1'b1;
            state_next = S_IDLE;
          end else if (stat.at_first) begin
            cmd.pop_front = 1'b1;
            cmd.emit      = 1'b1;
            state_next    = S_IDLE;
          end else if (stat.at_last) begin
            cmd.pop_back = 1'b1;
            cmd.emit     = 1'b1;
            state_next   = S_IDLE;
          end else begin
            cmd.shift_init = 1'b1;
            state_next     = S_SHIFT;
          end
        end else if (stat.rd_valid && stat.at_last) begin
          cmd.emit   = 1'b1;
          cmd.status = ST_MISSING;
          state_next = S_IDLE;
        end else begin
          cmd.rd_issue = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd.rd_issue  = 1'b1;
        cmd.shift_run = 1'b1;
        if (stat.rd_valid && stat.at_last) begin
          cmd.rd_issue = 1'b0;
          cmd.pop_back = 1'b1;
          cmd.emit     = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      is_del <= 1'b0;
    end else begin
      state  <= state_next;
      is_del <= is_del_next;
    end
  end

endmodule

>>> design/bounded_deque_with_search_top.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_search_top: bounded deque with search and delete
// Ordered list of signed 32-bit values, pushed and popped at either end,
// searched or deleted by value (first match from the front).
// ----------------------------------------------------------------------------
//
//  channel  | handshake               | fields
//  ---------+-------------------------+---------------------------------
//  request  | start in, busy out      | action[2:0], value[31:0] signed
//  result   | done out (one cycle)    | status[1:0], entry_count[4:0]
//
//  An item is taken on a clock edge with start high and busy low.
//  Pushes, pops and unused codes: the result strobes on the next cycle and
//  a new item may follow at once. Search/delete walk the store one entry a
//  cycle through its single registered read port (an empty list reports at
//  once); an interior delete then compacts the tail, one entry a cycle.
//  Reset (rst, synchronous) empties the list; stored values are left as is.
//  The receiver cannot stall: done lasts one cycle and is never held.
//
module bounded_deque_with_search_top #(
  parameter int CAPACITY = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [2:0]                            action,
  input  logic signed [bdq_pkg::VALUE_W-1:0]    value,
  output logic                                  done,
  output logic [1:0]                            status,
  output logic [bdq_pkg::COUNT_OUT_W-1:0]       entry_count
);
  import bdq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer: decode, scan and compaction control
  bdq_controller u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  // circular store, read pipeline and result register
  bdq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .value       (value),
    .cmd         (cmd),
    .stat        (stat),
    .done        (done),
    .status      (status),
    .entry_count (entry_count)
  );

  // end-point operations always answer on the very next cycle
  a_quick_ops: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (action == ACT_PUSH_FRONT || action == ACT_PUSH_BACK ||
                        action == ACT_POP_FRONT || action == ACT_POP_BACK))
    |=> done)
    else $error("end-point operation did not answer next cycle");

  // a full or empty report only ever follows a freshly taken item
  a_flag_origin: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_FULL || status == ST_EMPTY)) |-> $past(start && !busy))
    else $error("full/empty status without a request the cycle before");

  // at most one list update per cycle
  a_one_update: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.push_front, cmd.push_back, cmd.pop_front, cmd.pop_back,
              cmd.scan_init, cmd.shift_init}))
    else $error("conflicting list updates");

endmodule
